/* rtl/sts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared sizes, codes and the cell entry and command types.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int TIMERS = 64;
    localparam int IDX_W  = $clog2(TIMERS);
    localparam int DL_W   = 63;
    localparam int ID_W   = 6;
    localparam int TICK_W = 33;
    localparam int POLL_W = 7;

    localparam logic [DL_W-1:0]   DL_MAX     = {DL_W{1'b1}};
    localparam logic [TICK_W-1:0] TICK_RESET = 33'd4294967;
    localparam logic [POLL_W-1:0] POLL_MAX   = 7'd64;

    localparam logic [2:0] OP_ARM    = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_POLL   = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_TICKS  = 3'd4;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_EXP  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;
    localparam logic [1:0] KIND_DL   = 2'd3;

    typedef struct packed {
        logic            used;
        logic [DL_W-1:0] deadline;
        logic [ID_W-1:0] timer;
    } t_entry;

    typedef struct packed {
        logic            rm;
        logic            ins;
        logic            pop;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
    } t_cmd;

endpackage

/* rtl/sorted_timer_queue_unit.sv */
`timescale 1ns / 1ps
// Steps: arm runs calc, remove, insert, response; rearm by ticks adds MHI and
//   PROD first; cancel runs remove, response; query and others only response.
// Throughput: one item at a time; poll gives one expired word per cycle from
//   the head cell while the output is free; rearm multiplies 33x32, 33x31.
// Reset: synchronous, clears all used bits and output valid; the registers
//   return to tick_length 4294967 and max_per_poll 64. No clearing pass.
// ----------------------------------------------------------------------------
// Sorted timer queue unit
// Sequencer, deadline arithmetic, config registers and output register
// around a sorted chain of timer cells.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_op,
    input  logic [sts_pkg::ID_W-1:0]    i_timer_id,
    input  logic [sts_pkg::DL_W-1:0]    i_time_value,
    input  logic                        i_absolute,
    input  logic [sts_pkg::DL_W-1:0]    i_now,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_kind,
    output logic [sts_pkg::ID_W-1:0]    o_timer_id_out,
    output logic                        o_was_pending,
    output logic [sts_pkg::DL_W-1:0]    o_earliest,
    output logic                        o_empty_res,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import sts_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MHI  = 3'd1;
    localparam logic [2:0] S_PROD = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_REM  = 3'd4;
    localparam logic [2:0] S_INS  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;
    localparam logic [2:0] S_POLL = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [TICK_W-1:0] r_tick;
    logic [POLL_W-1:0] r_mpp;
    logic [2:0]        r_op;
    logic [ID_W-1:0]   r_id;
    logic [DL_W-1:0]   r_tv, r_now, r_prod, r_dl;
    logic              r_abs, r_was;
    logic [64:0]       r_plo;
    logic [63:0]       r_phi;
    logic [POLL_W-1:0] r_k;

    logic              r_ovalid;
    logic [1:0]        r_kind;
    logic [ID_W-1:0]   r_oid;
    logic              r_opend, r_oempty, r_olast;
    logic [DL_W-1:0]   r_oearly;

    t_cmd              cmd;
    t_entry            head0, head1;
    logic              found, full;
    logic [TIMERS-1:0] used;

    logic              accept, out_free, wr;
    logic              exp0, exp1, poll_last, emit_exp;
    logic [POLL_W-1:0] lim;
    logic [95:0]       prod_sum;
    logic [DL_W-1:0]   addend;
    logic [63:0]       now_sum;

    assign pready     = 1'b1;
    assign prdata     = paddr[3] ? {{(64-POLL_W){1'b0}}, r_mpp} : {{(64-TICK_W){1'b0}}, r_tick};
    assign wr         = psel && penable && pwrite;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_ovalid || i_out_ready;

    assign lim = (r_mpp == '0) ? POLL_W'(1) : ((r_mpp > POLL_MAX) ? POLL_MAX : r_mpp);
    assign exp0 = head0.used && (head0.deadline <= r_now);
    assign exp1 = head1.used && (head1.deadline <= r_now);
    assign poll_last = ((r_k + POLL_W'(1)) == lim) || !exp1;
    assign emit_exp  = (r_state == S_POLL) && out_free && exp0;

    assign prod_sum = {r_phi, 32'b0} + {31'b0, r_plo};
    assign addend   = (r_op == OP_TICKS) ? r_prod : r_tv;
    assign now_sum  = {1'b0, r_now} + {1'b0, addend};

    always_comb begin
        cmd     = '0;
        cmd.id  = r_id;
        cmd.dl  = r_dl;
        cmd.rm  = (r_state == S_REM);
        cmd.ins = (r_state == S_INS) && !full;
        cmd.pop = emit_exp;
    end

    sts_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_head0 (head0),
        .o_head1 (head1),
        .o_found (found),
        .o_full  (full),
        .o_used  (used)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority case (i_op)
                        OP_ARM:    n_state = S_CALC;
                        OP_TICKS:  n_state = S_MHI;
                        OP_CANCEL: n_state = S_REM;
                        OP_POLL:   n_state = S_POLL;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_MHI:  n_state = S_PROD;
            S_PROD: n_state = S_CALC;
            S_CALC: n_state = S_REM;
            S_REM:  n_state = (r_op == OP_CANCEL) ? S_RESP : S_INS;
            S_INS:  n_state = S_RESP;
            S_RESP: n_state = out_free ? S_IDLE : S_RESP;
            S_POLL: begin
                if (out_free && (!exp0 || poll_last)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= TICK_RESET;
            r_mpp    <= POLL_MAX;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr && paddr[3]) begin
                r_mpp <= pwdata[POLL_W-1:0];
            end else if (wr) begin
                r_tick <= pwdata[TICK_W-1:0];
            end
            if ((r_state == S_RESP && out_free) || (r_state == S_POLL && out_free)) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_id  <= i_timer_id;
            r_tv  <= i_time_value;
            r_abs <= i_absolute;
            r_now <= i_now;
            r_k   <= '0;
            r_plo <= r_tick * i_time_value[31:0];
        end
        if (r_state == S_MHI) begin
            r_phi <= r_tick * r_tv[DL_W-1:32];
        end
        if (r_state == S_PROD) begin
            r_prod <= (prod_sum[95:DL_W] != '0) ? DL_MAX : prod_sum[DL_W-1:0];
        end
        if (r_state == S_CALC) begin
            if (r_op == OP_ARM && r_abs) begin
                r_dl <= r_tv;
            end else begin
                r_dl <= now_sum[63] ? DL_MAX : now_sum[DL_W-1:0];
            end
        end
        if (r_state == S_REM) begin
            r_was <= found;
        end
        if (emit_exp) begin
            r_k <= r_k + POLL_W'(1);
        end

        if (r_state == S_RESP && out_free) begin
            r_oid    <= r_id;
            r_olast  <= 1'b1;
            r_oempty <= 1'b0;
            r_oearly <= '0;
            r_opend  <= 1'b0;
            r_kind   <= KIND_ACK;
            if (r_op == OP_QUERY) begin
                r_kind   <= KIND_DL;
                r_oempty <= !head0.used;
                r_oearly <= head0.used ? head0.deadline : '0;
            end else if (r_op == OP_ARM || r_op == OP_TICKS || r_op == OP_CANCEL) begin
                r_opend <= r_was;
            end
        end else if (r_state == S_POLL && out_free) begin
            r_opend  <= 1'b0;
            r_oempty <= 1'b0;
            r_oearly <= '0;
            if (exp0) begin
                r_kind  <= KIND_EXP;
                r_oid   <= head0.timer;
                r_olast <= poll_last;
            end else begin
                r_kind  <= KIND_NONE;
                r_oid   <= r_id;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_kind         = r_kind;
    assign o_timer_id_out = r_oid;
    assign o_was_pending  = r_opend;
    assign o_earliest     = r_oearly;
    assign o_empty_res    = r_oempty;
    assign o_last         = r_olast;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word did not start the sequencer");

    a_used_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, used} + {{TIMERS{1'b0}}, 1'b1}))
        else $error("used cells do not form a prefix");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_exp |=> ($countones(used) == $countones($past(used)) - 1))
        else $error("expired word without head removal");

endmodule

/* rtl/sts_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// Holds one entry; shifts toward the head on removal and toward the tail on
// insertion, taking data from its neighbors.
// ----------------------------------------------------------------------------
module sts_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sts_pkg::t_cmd   i_cmd,
    input  sts_pkg::t_entry i_left,
    input  sts_pkg::t_entry i_right,
    input  logic           i_ins_left,
    input  logic           i_seen_left,
    output sts_pkg::t_entry o_entry,
    output logic           o_ins,
    output logic           o_seen
);
    import sts_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   match;

    assign match   = r_entry.used && (r_entry.timer == i_cmd.id) && i_cmd.rm;
    assign o_seen  = i_seen_left | match;
    // new deadline belongs here or earlier; ties stay behind older entries
    assign o_ins   = !r_entry.used || (i_cmd.dl < r_entry.deadline);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if ((i_cmd.rm || i_cmd.pop) && o_seen) begin
            n_entry = i_right;
        end else if (i_cmd.ins && o_ins) begin
            if (i_ins_left) begin
                n_entry = i_left;
            end else begin
                n_entry = '{used: 1'b1, deadline: i_cmd.dl, timer: i_cmd.id};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.used <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

/* rtl/sts_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue chain
// Row of cells in deadline order, head at cell zero.
// ----------------------------------------------------------------------------
module sts_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sts_pkg::t_cmd                i_cmd,
    output sts_pkg::t_entry              o_head0,
    output sts_pkg::t_entry              o_head1,
    output logic                        o_found,
    output logic                        o_full,
    output logic [sts_pkg::TIMERS-1:0]  o_used
);
    import sts_pkg::*;

    t_entry ent  [TIMERS];
    logic   ins  [TIMERS];
    logic   seen [TIMERS];

    for (genvar g = 0; g < TIMERS; g++) begin : g_cell
        t_entry left;
        t_entry right;
        logic   ins_left;
        logic   seen_left;

        if (g == 0) begin : g_head
            assign left      = '0;
            assign ins_left  = 1'b0;
            assign seen_left = i_cmd.pop;
        end else begin : g_body
            assign left      = ent[g-1];
            assign ins_left  = ins[g-1];
            assign seen_left = seen[g-1];
        end

        if (g == TIMERS - 1) begin : g_tail
            assign right = '0;
        end else begin : g_next
            assign right = ent[g+1];
        end

        sts_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (i_cmd),
            .i_left      (left),
            .i_right     (right),
            .i_ins_left  (ins_left),
            .i_seen_left (seen_left),
            .o_entry     (ent[g]),
            .o_ins       (ins[g]),
            .o_seen      (seen[g])
        );

        assign o_used[g] = ent[g].used;
    end

    assign o_head0 = ent[0];
    assign o_head1 = ent[1];
    assign o_found = seen[TIMERS-1];
    assign o_full  = ent[TIMERS-1].used;

endmodule
